// File: design/cwm_pkg.sv
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared widths, latencies, register codes and the arctangent angle table
// of the cylindrical warp mapper.
// ----------------------------------------------------------------------------
package cwm_pkg;

	// image size limits
	localparam int MAX_ROWS  = 4096;
	localparam int MAX_COLS  = 4096;
	localparam int ROW_LIMIT = (MAX_ROWS - 1) < 4095 ? (MAX_ROWS - 1) : 4095;
	localparam int COL_LIMIT = (MAX_COLS - 1) < 4095 ? (MAX_COLS - 1) : 4095;

	// field widths
	localparam int FL_W  = 24;
	localparam int DIM_W = 13;
	localparam int CRD_W = 12;
	localparam int PIX_W = 8;

	// row offset search
	localparam int ROW_BITS = 12;
	localparam int SQ_W     = 2 * CRD_W;
	localparam int F2_W     = 2 * FL_W;
	localparam int S_W      = F2_W + 1;
	localparam int R_W      = 76;
	localparam int P_W      = 76;
	localparam int Q_W      = 64;

	// arctangent lanes
	localparam int CORDIC_STEPS = 31;
	localparam int CW           = 58;
	localparam int ZW           = 33;
	localparam int ZU_W         = 31;
	localparam int PROD_W       = FL_W + ZU_W;
	localparam int ROUND_SHIFT  = 38;
	localparam int ARC_W        = 17;

	// pipeline latencies
	localparam int ARC_LAT    = CORDIC_STEPS + 2;
	localparam int PRE_LAT    = 3;
	localparam int SEARCH_LAT = ROW_BITS;
	localparam int K_DLY      = ARC_LAT - PRE_LAT - SEARCH_LAT;
	localparam int OUT_LAT    = ARC_LAT + 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

	// reset values of the configuration registers
	localparam logic [FL_W-1:0]  FOCAL_RST = 24'd179200;
	localparam logic [DIM_W-1:0] ROWS_RST  = 13'd1024;
	localparam logic [DIM_W-1:0] COLS_RST  = 13'd1024;

	// per-item data that rides alongside the arithmetic
	typedef struct packed {
		logic [CRD_W-1:0] hr;
		logic             neg_n;
		logic             neg_d;
		logic             fz;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} side_t;

	// atan(2^-i) in Q30 radians
	function automatic logic [ZU_W-1:0] arc_angle(input int unsigned idx);
		case (idx)
			0:       return 31'd843314856;
			1:       return 31'd497837829;
			2:       return 31'd263043836;
			3:       return 31'd133525158;
			4:       return 31'd67021686;
			5:       return 31'd33543515;
			6:       return 31'd16775850;
			7:       return 31'd8388437;
			8:       return 31'd4194282;
			9:       return 31'd2097149;
			10:      return 31'd1048575;
			11:      return 31'd524287;
			12:      return 31'd262143;
			13:      return 31'd131071;
			14:      return 31'd65535;
			15:      return 31'd32767;
			16:      return 31'd16383;
			17:      return 31'd8191;
			18:      return 31'd4095;
			19:      return 31'd2047;
			20:      return 31'd1023;
			21:      return 31'd511;
			22:      return 31'd255;
			23:      return 31'd127;
			24:      return 31'd63;
			25:      return 31'd31;
			26:      return 31'd15;
			27:      return 31'd8;
			28:      return 31'd4;
			29:      return 31'd2;
			30:      return 31'd1;
			default: return '0;
		endcase
	endfunction

endpackage

// File: design/cwm_row_search.sv
// ----------------------------------------------------------------------------
// cwm_row_search
// Pipelined bit-by-bit search for the rounded row offset k: the largest k
// with (2k-1)^2 * S <= R, one bit of k per stage, using only shifts and adds.
// ----------------------------------------------------------------------------
module cwm_row_search (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cwm_pkg::S_W-1:0]       s_in,
	input  logic [cwm_pkg::R_W-1:0]       r_in,
	output logic [cwm_pkg::ROW_BITS-1:0]  k
);

	// per stage: k so far, P = (2k-1)^2 S, Q = (2k-1) S, and the operands
	logic        [cwm_pkg::ROW_BITS-1:0] k_q [cwm_pkg::ROW_BITS];
	logic        [cwm_pkg::P_W-1:0]      p_q [cwm_pkg::ROW_BITS];
	logic signed [cwm_pkg::Q_W-1:0]      q_q [cwm_pkg::ROW_BITS];
	logic        [cwm_pkg::S_W-1:0]      s_q [cwm_pkg::ROW_BITS];
	logic        [cwm_pkg::R_W-1:0]      r_q [cwm_pkg::ROW_BITS];

	for (genvar st = 0; st < cwm_pkg::ROW_BITS; st++) begin : g_stage
		localparam int J = cwm_pkg::ROW_BITS - 1 - st;

		logic        [cwm_pkg::ROW_BITS-1:0] k_i;
		logic        [cwm_pkg::P_W-1:0]      p_i;
		logic signed [cwm_pkg::Q_W-1:0]      q_i;
		logic        [cwm_pkg::S_W-1:0]      s_i;
		logic        [cwm_pkg::R_W-1:0]      r_i;
		logic        [cwm_pkg::P_W-1:0]      s_sq;
		logic signed [cwm_pkg::P_W+1:0]      q_sh;
		logic signed [cwm_pkg::P_W+1:0]      p_c;
		logic signed [cwm_pkg::Q_W-1:0]      q_c;
		logic                                take;

		// start at k = 0, so 2k-1 = -1
		if (st == 0) begin : g_first
			assign k_i = '0;
			assign p_i = cwm_pkg::P_W'(s_in);
			assign q_i = -$signed(cwm_pkg::Q_W'(s_in));
			assign s_i = s_in;
			assign r_i = r_in;
		end else begin : g_next
			assign k_i = k_q[st-1];
			assign p_i = p_q[st-1];
			assign q_i = q_q[st-1];
			assign s_i = s_q[st-1];
			assign r_i = r_q[st-1];
		end

		// candidate with bit J set: (u + 2^(J+1))^2 S
		always_comb begin
			s_sq = cwm_pkg::P_W'(s_i) << (2 * J + 2);
			q_sh = (cwm_pkg::P_W + 2)'(q_i) <<< (J + 2);
			p_c  = $signed({2'b00, p_i}) + q_sh + $signed({2'b00, s_sq});
			q_c  = q_i + $signed(cwm_pkg::Q_W'(s_i) << (J + 1));
			take = p_c <= $signed({2'b00, r_i});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				k_q[st] <= take ? (k_i | (cwm_pkg::ROW_BITS'(1) << J)) : k_i;
				p_q[st] <= take ? p_c[cwm_pkg::P_W-1:0] : p_i;
				q_q[st] <= take ? q_c : q_i;
				s_q[st] <= s_i;
				r_q[st] <= r_i;
			end
		end
	end

	assign k = k_q[cwm_pkg::ROW_BITS-1];

endmodule

// File: design/cwm_arc_lane.sv
// ----------------------------------------------------------------------------
// cwm_arc_lane
// Pipelined CORDIC vectoring lane: A(m) = round(F * atan(256m/F) / 2^38)
// with one rotation per stage, then a scaling multiply and a rounding stage.
// ----------------------------------------------------------------------------
module cwm_arc_lane (
	input  logic                         clk,
	input  logic                         en,
	input  logic [cwm_pkg::FL_W-1:0]     fl,
	input  logic [cwm_pkg::CRD_W-1:0]    m,
	output logic [cwm_pkg::ARC_W-1:0]    a
);

	logic signed [cwm_pkg::CW-1:0]   x_q  [cwm_pkg::CORDIC_STEPS];
	logic signed [cwm_pkg::CW-1:0]   y_q  [cwm_pkg::CORDIC_STEPS];
	logic signed [cwm_pkg::ZW-1:0]   z_q  [cwm_pkg::CORDIC_STEPS];
	logic        [cwm_pkg::FL_W-1:0] f_q  [cwm_pkg::CORDIC_STEPS];
	logic                            zf_q [cwm_pkg::CORDIC_STEPS];

	logic [cwm_pkg::PROD_W-1:0] prod_q;
	logic                       zf_prod_q;
	logic [cwm_pkg::ZU_W-1:0]   z_clip;
	logic [cwm_pkg::PROD_W:0]   prod_rnd;
	logic [cwm_pkg::ARC_W-1:0]  a_q;

	for (genvar i = 0; i < cwm_pkg::CORDIC_STEPS; i++) begin : g_step
		logic signed [cwm_pkg::CW-1:0]   x_i;
		logic signed [cwm_pkg::CW-1:0]   y_i;
		logic signed [cwm_pkg::ZW-1:0]   z_i;
		logic        [cwm_pkg::FL_W-1:0] f_i;
		logic                            zf_i;
		logic signed [cwm_pkg::CW-1:0]   xs;
		logic signed [cwm_pkg::CW-1:0]   ys;
		logic signed [cwm_pkg::ZW-1:0]   ang;
		logic                            pos;

		// start vector (F, 256m) scaled by 2^30
		if (i == 0) begin : g_first
			assign x_i  = $signed(cwm_pkg::CW'(fl) << 30);
			assign y_i  = $signed(cwm_pkg::CW'(m) << 38);
			assign z_i  = '0;
			assign f_i  = fl;
			assign zf_i = (m == '0) || (fl == '0);
		end else begin : g_next
			assign x_i  = x_q[i-1];
			assign y_i  = y_q[i-1];
			assign z_i  = z_q[i-1];
			assign f_i  = f_q[i-1];
			assign zf_i = zf_q[i-1];
		end

		// one rotation toward the x axis
		always_comb begin
			xs  = x_i >>> i;
			ys  = y_i >>> i;
			ang = $signed({2'b00, cwm_pkg::arc_angle(i)});
			pos = !y_i[cwm_pkg::CW-1] && (y_i != '0);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[i]  <= pos ? x_i + ys : x_i - ys;
				y_q[i]  <= pos ? y_i - xs : y_i + xs;
				z_q[i]  <= pos ? z_i + ang : z_i - ang;
				f_q[i]  <= f_i;
				zf_q[i] <= zf_i;
			end
		end
	end

	// negative angle counts as zero
	assign z_clip = z_q[cwm_pkg::CORDIC_STEPS-1][cwm_pkg::ZW-1] ? '0
		: z_q[cwm_pkg::CORDIC_STEPS-1][cwm_pkg::ZU_W-1:0];

	// scale the angle by the focal length
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q    <= cwm_pkg::PROD_W'(f_q[cwm_pkg::CORDIC_STEPS-1])
				* cwm_pkg::PROD_W'(z_clip);
			zf_prod_q <= zf_q[cwm_pkg::CORDIC_STEPS-1];
		end
	end

	// round half up and drop the fraction
	assign prod_rnd = (cwm_pkg::PROD_W + 1)'(prod_q)
		+ ((cwm_pkg::PROD_W + 1)'(1) << (cwm_pkg::ROUND_SHIFT - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			a_q <= zf_prod_q ? '0
				: prod_rnd[cwm_pkg::ROUND_SHIFT +: cwm_pkg::ARC_W];
		end
	end

	assign a = a_q;

endmodule

// File: design/cylindrical_warp_mapper.sv
// ----------------------------------------------------------------------------
// cylindrical_warp_mapper
// Throughput: one pixel per cycle while no result is held at the output;
// the 31-step CORDIC lanes and the 12-step row offset search are fully
// pipelined, one step per stage.
// Reset: clears all valid bits and loads the register reset values.
// Maps a source pixel onto a cylinder and passes its color through.
// ----------------------------------------------------------------------------
module cylindrical_warp_mapper (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cwm_pkg::FL_W-1:0]          cfg_data,
	// source pixels
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic [cwm_pkg::CRD_W-1:0]         src_row,
	input  logic [cwm_pkg::CRD_W-1:0]         src_col,
	input  logic [cwm_pkg::PIX_W-1:0]         pixel_red,
	input  logic [cwm_pkg::PIX_W-1:0]         pixel_green,
	input  logic [cwm_pkg::PIX_W-1:0]         pixel_blue,
	// mapped pixels
	output logic                              map_valid,
	input  logic                              map_ready,
	output logic [cwm_pkg::CRD_W-1:0]         dest_row,
	output logic [cwm_pkg::CRD_W-1:0]         dest_col,
	output logic [cwm_pkg::PIX_W-1:0]         out_red,
	output logic [cwm_pkg::PIX_W-1:0]         out_green,
	output logic [cwm_pkg::PIX_W-1:0]         out_blue
);

	logic [cwm_pkg::FL_W-1:0]  focal_length_q;
	logic [cwm_pkg::DIM_W-1:0] image_rows_q;
	logic [cwm_pkg::DIM_W-1:0] image_cols_q;

	logic en;
	logic vld_q [cwm_pkg::OUT_LAT];

	// front end
	logic        [cwm_pkg::CRD_W-1:0] hr_c;
	logic        [cwm_pkg::CRD_W-1:0] hc_c;
	logic signed [cwm_pkg::CRD_W:0]   n_c;
	logic signed [cwm_pkg::CRD_W:0]   d_c;
	logic signed [cwm_pkg::CRD_W:0]   mn_c;
	logic signed [cwm_pkg::CRD_W:0]   md_c;

	logic [cwm_pkg::CRD_W-1:0] mn_s1;
	logic [cwm_pkg::CRD_W-1:0] md_s1;
	logic [cwm_pkg::CRD_W-1:0] hc_s1;
	logic [cwm_pkg::FL_W-1:0]  fl_s1;
	cwm_pkg::side_t            side_s1;

	logic [cwm_pkg::SQ_W-1:0] n2_s2;
	logic [cwm_pkg::SQ_W-1:0] d2_s2;
	logic [cwm_pkg::F2_W-1:0] f2_s2;

	logic [cwm_pkg::S_W-1:0]  s_s3;
	logic [cwm_pkg::F2_W-1:0] rlo_s3;
	logic [cwm_pkg::F2_W-1:0] rhi_s3;

	logic [cwm_pkg::S_W-1:0] s_s4;
	logic [cwm_pkg::R_W-1:0] r_s4;

	logic [cwm_pkg::ROW_BITS-1:0] k_srch;
	logic [cwm_pkg::ROW_BITS-1:0] k_dly [cwm_pkg::K_DLY];
	cwm_pkg::side_t               side_dly [cwm_pkg::ARC_LAT];

	logic [cwm_pkg::ARC_W-1:0] a_d;
	logic [cwm_pkg::ARC_W-1:0] a_h;

	// back end
	cwm_pkg::side_t                      side_e;
	logic        [cwm_pkg::ROW_BITS-1:0] k_e;
	logic signed [cwm_pkg::CRD_W+1:0]    row_c;
	logic signed [cwm_pkg::ARC_W+1:0]    col_c;
	logic        [cwm_pkg::CRD_W-1:0]    row_sat;
	logic        [cwm_pkg::CRD_W-1:0]    col_sat;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_length_q <= cwm_pkg::FOCAL_RST;
			image_rows_q   <= cwm_pkg::ROWS_RST;
			image_cols_q   <= cwm_pkg::COLS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cwm_pkg::CFG_FOCAL: focal_length_q <= cfg_data;
				cwm_pkg::CFG_ROWS:  image_rows_q   <= cfg_data[cwm_pkg::DIM_W-1:0];
				cwm_pkg::CFG_COLS:  image_cols_q   <= cfg_data[cwm_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// the whole pipeline moves unless a result is held at the output
	assign en        = !map_valid || map_ready;
	assign pix_ready = en;
	assign map_valid = vld_q[cwm_pkg::OUT_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cwm_pkg::OUT_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= pix_valid;
			for (int i = 1; i < cwm_pkg::OUT_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// centered coordinates and their magnitudes
	always_comb begin
		hr_c = image_rows_q[cwm_pkg::DIM_W-1:1];
		hc_c = image_cols_q[cwm_pkg::DIM_W-1:1];
		n_c  = $signed({1'b0, src_row}) - $signed({1'b0, hr_c});
		d_c  = $signed({1'b0, src_col}) - $signed({1'b0, hc_c});
		mn_c = n_c[cwm_pkg::CRD_W] ? -n_c : n_c;
		md_c = d_c[cwm_pkg::CRD_W] ? -d_c : d_c;
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (en) begin
			mn_s1         <= mn_c[cwm_pkg::CRD_W-1:0];
			md_s1         <= md_c[cwm_pkg::CRD_W-1:0];
			hc_s1         <= hc_c;
			fl_s1         <= focal_length_q;
			side_s1.hr    <= hr_c;
			side_s1.neg_n <= n_c[cwm_pkg::CRD_W];
			side_s1.neg_d <= d_c[cwm_pkg::CRD_W];
			side_s1.fz    <= focal_length_q == '0;
			side_s1.red   <= pixel_red;
			side_s1.green <= pixel_green;
			side_s1.blue  <= pixel_blue;
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (en) begin
			n2_s2 <= cwm_pkg::SQ_W'(mn_s1) * cwm_pkg::SQ_W'(mn_s1);
			d2_s2 <= cwm_pkg::SQ_W'(md_s1) * cwm_pkg::SQ_W'(md_s1);
			f2_s2 <= cwm_pkg::F2_W'(fl_s1) * cwm_pkg::F2_W'(fl_s1);
		end
	end

	// stage 3: S = 65536 d^2 + F^2 and the two halves of n^2 F^2
	always_ff @(posedge clk) begin
		if (en) begin
			s_s3   <= (cwm_pkg::S_W'(d2_s2) << 16) + cwm_pkg::S_W'(f2_s2);
			rlo_s3 <= cwm_pkg::F2_W'(n2_s2) * cwm_pkg::F2_W'(f2_s2[cwm_pkg::FL_W-1:0]);
			rhi_s3 <= cwm_pkg::F2_W'(n2_s2)
				* cwm_pkg::F2_W'(f2_s2[cwm_pkg::F2_W-1:cwm_pkg::FL_W]);
		end
	end

	// stage 4: R = 4 n^2 F^2
	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= s_s3;
			r_s4 <= ((cwm_pkg::R_W'(rhi_s3) << cwm_pkg::FL_W) + cwm_pkg::R_W'(rlo_s3)) << 2;
		end
	end

	cwm_row_search u_row_search (
		.clk  (clk),
		.en   (en),
		.s_in (s_s4),
		.r_in (r_s4),
		.k    (k_srch)
	);

	// arctangent of the pixel column and of the crop origin
	cwm_arc_lane u_arc_col (
		.clk (clk),
		.en  (en),
		.fl  (fl_s1),
		.m   (md_s1),
		.a   (a_d)
	);

	cwm_arc_lane u_arc_origin (
		.clk (clk),
		.en  (en),
		.fl  (fl_s1),
		.m   (hc_s1),
		.a   (a_h)
	);

	// align the row offset and side data with the arctangent lanes
	always_ff @(posedge clk) begin
		if (en) begin
			k_dly[0]    <= k_srch;
			side_dly[0] <= side_s1;
			for (int i = 1; i < cwm_pkg::K_DLY; i++) begin
				k_dly[i] <= k_dly[i-1];
			end
			for (int i = 1; i < cwm_pkg::ARC_LAT; i++) begin
				side_dly[i] <= side_dly[i-1];
			end
		end
	end

	// final coordinates with saturation
	always_comb begin
		side_e = side_dly[cwm_pkg::ARC_LAT-1];
		k_e    = side_e.fz ? '0 : k_dly[cwm_pkg::K_DLY-1];
		row_c  = side_e.neg_n
			? $signed({2'b00, side_e.hr}) - $signed({2'b00, k_e})
			: $signed({2'b00, side_e.hr}) + $signed({2'b00, k_e});
		col_c  = (side_e.neg_d ? -$signed({2'b00, a_d}) : $signed({2'b00, a_d}))
			+ $signed({2'b00, a_h});

		if (row_c[cwm_pkg::CRD_W+1]) begin
			row_sat = '0;
		end else if (row_c > (cwm_pkg::CRD_W + 2)'(cwm_pkg::ROW_LIMIT)) begin
			row_sat = cwm_pkg::CRD_W'(cwm_pkg::ROW_LIMIT);
		end else begin
			row_sat = row_c[cwm_pkg::CRD_W-1:0];
		end

		if (col_c[cwm_pkg::ARC_W+1]) begin
			col_sat = '0;
		end else if (col_c > (cwm_pkg::ARC_W + 2)'(cwm_pkg::COL_LIMIT)) begin
			col_sat = cwm_pkg::CRD_W'(cwm_pkg::COL_LIMIT);
		end else begin
			col_sat = col_c[cwm_pkg::CRD_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			dest_row  <= row_sat;
			dest_col  <= col_sat;
			out_red   <= side_e.red;
			out_green <= side_e.green;
			out_blue  <= side_e.blue;
		end
	end

endmodule

// File: verif/cylindrical_warp_mapper_test.sv
// ----------------------------------------------------------------------------
// cylindrical_warp_mapper_test
// Streams source pixels through the cylindrical warp mapper under several
// focal length and image size settings, with random gaps on the pixel side
// and random stalls on the result side, and checks every mapped pixel
// against an independent bit-exact model of the projection.
// ----------------------------------------------------------------------------
module cylindrical_warp_mapper_test;

	// one mapped pixel
	typedef struct {
		logic [cwm_pkg::CRD_W-1:0] row;
		logic [cwm_pkg::CRD_W-1:0] col;
		logic [cwm_pkg::PIX_W-1:0] red;
		logic [cwm_pkg::PIX_W-1:0] green;
		logic [cwm_pkg::PIX_W-1:0] blue;
	} mapped_t;

	// projection model and store of pending mapped pixels
	class warp_checker;
		logic [cwm_pkg::FL_W-1:0]  focal;
		logic [cwm_pkg::DIM_W-1:0] rows;
		logic [cwm_pkg::DIM_W-1:0] cols;
		mapped_t                   pending_maps[$];
		longint                    atan_q30[31];
		int                        errors;
		int                        checked;

		function new();
			atan_q30 = '{843314856, 497837829, 263043836, 133525158, 67021686,
				33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
				262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
				255, 127, 63, 31, 15, 8, 4, 2, 1};
			focal = cwm_pkg::FOCAL_RST;
			rows = cwm_pkg::ROWS_RST;
			cols = cwm_pkg::COLS_RST;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [cwm_pkg::CFG_IDX_W-1:0] idx,
				logic [cwm_pkg::FL_W-1:0] data);
			case (idx)
				cwm_pkg::CFG_FOCAL: focal = data;
				cwm_pkg::CFG_ROWS:  rows = data[cwm_pkg::DIM_W-1:0];
				cwm_pkg::CFG_COLS:  cols = data[cwm_pkg::DIM_W-1:0];
				default: ;
			endcase
		endfunction

		// largest k in [0,mn] with (2k-1)^2 * (65536 d^2 + F^2) <= 4 n^2 F^2
		function longint row_shift(longint mn, longint md);
			logic [127:0] s, t2, q, p;
			longint lo, hi, mid;
			if (focal == 0)
				return 0;
			s = 128'(65536 * md * md) + 128'(focal) * 128'(focal);
			t2 = 128'(2 * mn) * 128'(focal);
			t2 = t2 * t2;
			lo = 0;
			hi = mn;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				q = 128'((2 * mid - 1) * (2 * mid - 1));
				p = q * s;
				if (p <= t2)
					lo = mid;
				else
					hi = mid - 1;
			end
			return lo;
		endfunction

		// round(F * atan(256m/F) / 2^38) by cordic vectoring in q30
		function longint arc_span(longint m);
			longint x, y, z, xs, ys;
			if (m == 0 || focal == 0)
				return 0;
			x = longint'(focal) <<< 30;
			y = (256 * m) <<< 30;
			z = 0;
			for (int i = 0; i < 31; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys; y -= xs; z += atan_q30[i];
				end else begin
					x -= ys; y += xs; z -= atan_q30[i];
				end
			end
			if (z < 0)
				z = 0;
			return (longint'(focal) * z + (longint'(1) <<< 37)) >>> 38;
		endfunction

		// accepted source pixel: work out its mapped pixel
		function void note_pixel(logic [cwm_pkg::CRD_W-1:0] r, logic [cwm_pkg::CRD_W-1:0] c,
				logic [cwm_pkg::PIX_W-1:0] red, logic [cwm_pkg::PIX_W-1:0] grn,
				logic [cwm_pkg::PIX_W-1:0] blu);
			longint hr, hc, n, d, k, row, col, a;
			mapped_t m;
			hr = rows >> 1;
			hc = cols >> 1;
			n = longint'(r) - hr;
			d = longint'(c) - hc;
			k = row_shift(n < 0 ? -n : n, d < 0 ? -d : d);
			row = hr + (n < 0 ? -k : k);
			a = arc_span(d < 0 ? -d : d);
			col = (d < 0 ? -a : a) + arc_span(hc);
			if (row < 0) row = 0;
			if (row > cwm_pkg::ROW_LIMIT) row = cwm_pkg::ROW_LIMIT;
			if (col < 0) col = 0;
			if (col > cwm_pkg::COL_LIMIT) col = cwm_pkg::COL_LIMIT;
			m.row = row[cwm_pkg::CRD_W-1:0];
			m.col = col[cwm_pkg::CRD_W-1:0];
			m.red = red;
			m.green = grn;
			m.blue = blu;
			pending_maps.insert(pending_maps.size(), m);
		endfunction

		// mapped pixel from the block: compare with the oldest expectation
		function void check_map(mapped_t got);
			mapped_t exp_m;
			if (pending_maps.size() == 0) begin
				$display("%0t: unexpected mapped pixel row %0d col %0d", $time,
					got.row, got.col);
				errors++;
				return;
			end
			exp_m = pending_maps.pop_front();
			checked++;
			if (got.row !== exp_m.row) begin
				$display("%0t: dest_row expected %0d actual %0d", $time, exp_m.row, got.row);
				errors++;
			end
			if (got.col !== exp_m.col) begin
				$display("%0t: dest_col expected %0d actual %0d", $time, exp_m.col, got.col);
				errors++;
			end
			if (got.red !== exp_m.red) begin
				$display("%0t: out_red expected %0d actual %0d", $time, exp_m.red, got.red);
				errors++;
			end
			if (got.green !== exp_m.green) begin
				$display("%0t: out_green expected %0d actual %0d", $time, exp_m.green,
					got.green);
				errors++;
			end
			if (got.blue !== exp_m.blue) begin
				$display("%0t: out_blue expected %0d actual %0d", $time, exp_m.blue, got.blue);
				errors++;
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [cwm_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [cwm_pkg::FL_W-1:0]        cfg_data;
	logic                            pix_valid;
	logic                            pix_ready;
	logic [cwm_pkg::CRD_W-1:0]       src_row;
	logic [cwm_pkg::CRD_W-1:0]       src_col;
	logic [cwm_pkg::PIX_W-1:0]       pixel_red;
	logic [cwm_pkg::PIX_W-1:0]       pixel_green;
	logic [cwm_pkg::PIX_W-1:0]       pixel_blue;
	logic                            map_valid;
	logic                            map_ready;
	logic [cwm_pkg::CRD_W-1:0]       dest_row;
	logic [cwm_pkg::CRD_W-1:0]       dest_col;
	logic [cwm_pkg::PIX_W-1:0]       out_red;
	logic [cwm_pkg::PIX_W-1:0]       out_green;
	logic [cwm_pkg::PIX_W-1:0]       out_blue;

	warp_checker chk = new();
	int          quiet_cycles = 0;
	int          stall_left = 0;
	int          sent_pixels = 0;
	int          settings_run = 0;
	bit          gaps_on = 1'b1;

	cylindrical_warp_mapper dut (.*);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			map_ready = 1'b0;
			stall_left--;
		end else begin
			map_ready = 1'b1;
			if (gaps_on && $urandom_range(0, 7) == 0)
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 70)
					: $urandom_range(1, 3);
		end
	end

	// result monitor
	always @(posedge clk) begin
		mapped_t got;
		if (arst_n && map_valid && map_ready) begin
			got.row = dest_row;
			got.col = dest_col;
			got.red = out_red;
			got.green = out_green;
			got.blue = out_blue;
			chk.check_map(got);
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (map_valid && map_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 5000) begin
			$display("cylindrical_warp_mapper test failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_pixel(logic [cwm_pkg::CRD_W-1:0] r, logic [cwm_pkg::CRD_W-1:0] c,
			logic [cwm_pkg::PIX_W-1:0] red, logic [cwm_pkg::PIX_W-1:0] grn,
			logic [cwm_pkg::PIX_W-1:0] blu);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			pix_valid = 1'b0;
		end
		@(negedge clk);
		pix_valid = 1'b1;
		src_row = r;
		src_col = c;
		pixel_red = red;
		pixel_green = grn;
		pixel_blue = blu;
		do @(posedge clk); while (!pix_ready);
		chk.note_pixel(r, c, red, grn, blu);
		sent_pixels++;
	endtask

	task automatic write_reg(logic [cwm_pkg::CFG_IDX_W-1:0] idx,
			logic [cwm_pkg::FL_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		chk.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// let the pipeline drain before touching the registers
	task automatic drain();
		@(negedge clk);
		pix_valid = 1'b0;
		while (chk.pending_maps.size() != 0)
			@(posedge clk);
		repeat (cwm_pkg::OUT_LAT + 5) @(posedge clk);
	endtask

	task automatic apply_setting(logic [cwm_pkg::FL_W-1:0] f, logic [cwm_pkg::DIM_W-1:0] nr,
			logic [cwm_pkg::DIM_W-1:0] nc);
		drain();
		write_reg(cwm_pkg::CFG_FOCAL, f);
		write_reg(cwm_pkg::CFG_ROWS, cwm_pkg::FL_W'(nr));
		write_reg(cwm_pkg::CFG_COLS, cwm_pkg::FL_W'(nc));
		settings_run++;
	endtask

	// mostly coordinates inside the image, some anywhere in the field
	task automatic random_pixels(int count);
		logic [cwm_pkg::CRD_W-1:0] r, c;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) != 0 && chk.rows > 1 && chk.cols > 1) begin
				r = cwm_pkg::CRD_W'($urandom_range(0,
					(chk.rows > 4096 ? 4096 : chk.rows) - 1));
				c = cwm_pkg::CRD_W'($urandom_range(0,
					(chk.cols > 4096 ? 4096 : chk.cols) - 1));
			end else begin
				r = cwm_pkg::CRD_W'($urandom);
				c = cwm_pkg::CRD_W'($urandom);
			end
			send_pixel(r, c, cwm_pkg::PIX_W'($urandom), cwm_pkg::PIX_W'($urandom),
				cwm_pkg::PIX_W'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cwm_pkg::CFG_FOCAL;
		cfg_data = '0;
		pix_valid = 1'b0;
		src_row = '0;
		src_col = '0;
		pixel_red = '0;
		pixel_green = '0;
		pixel_blue = '0;
		map_ready = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners at reset settings
		send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00);
		send_pixel(12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff);
		send_pixel(12'd512, 12'd512, 8'h55, 8'haa, 8'h0f);
		send_pixel(12'd0, 12'hfff, 8'hf0, 8'h01, 8'h80);
		send_pixel(12'hfff, 12'd0, 8'h7f, 8'hfe, 8'h10);
		send_pixel(12'd1023, 12'd1023, 8'h01, 8'h02, 8'h04);
		send_pixel(12'd511, 12'd513, 8'h08, 8'h20, 8'h40);
		send_pixel(12'h555, 12'haaa, 8'haa, 8'h55, 8'hc3);
		send_pixel(12'haaa, 12'h555, 8'h3c, 8'h96, 8'h69);
		// an unused register index must change nothing
		drain();
		write_reg(2'd3, 24'h000100);
		send_pixel(12'd100, 12'd900, 8'h11, 8'h22, 8'h33);
		// zero focal length
		apply_setting(24'd0, 13'd1024, 13'd1024);
		send_pixel(12'd0, 12'd0, 8'h12, 8'h34, 8'h56);
		send_pixel(12'hfff, 12'hfff, 8'h9a, 8'hbc, 8'hde);
		// smallest focal length, smallest image
		apply_setting(24'd256, 13'd2, 13'd2);
		send_pixel(12'd0, 12'd0, 8'h00, 8'hff, 8'h00);
		send_pixel(12'd1, 12'd1, 8'hff, 8'h00, 8'hff);
		send_pixel(12'hfff, 12'hfff, 8'h5a, 8'ha5, 8'h5a);
		// degenerate sizes with a half of zero
		apply_setting(24'd179200, 13'd1, 13'd0);
		send_pixel(12'd0, 12'd0, 8'h01, 8'h01, 8'h01);
		send_pixel(12'hfff, 12'hfff, 8'h02, 8'h02, 8'h02);
		// largest focal length and full size register
		apply_setting(24'hffffff, 13'h1fff, 13'h1fff);
		send_pixel(12'd0, 12'd0, 8'h03, 8'h03, 8'h03);
		send_pixel(12'hfff, 12'hfff, 8'h04, 8'h04, 8'h04);

		// random phases over a spread of settings
		apply_setting(cwm_pkg::FOCAL_RST, cwm_pkg::ROWS_RST, cwm_pkg::COLS_RST);
		random_pixels(300);
		apply_setting(24'd256, 13'd4096, 13'd4096);
		random_pixels(250);
		gaps_on = 1'b0;
		apply_setting(24'hffffff, 13'd4096, 13'd4096);
		random_pixels(200);
		gaps_on = 1'b1;
		apply_setting(24'd0, 13'd640, 13'd480);
		random_pixels(80);
		for (int p = 0; p < 6; p++) begin
			apply_setting(cwm_pkg::FL_W'($urandom), cwm_pkg::DIM_W'($urandom_range(0, 8191)),
				cwm_pkg::DIM_W'($urandom_range(0, 8191)));
			random_pixels(100);
			apply_setting(cwm_pkg::FL_W'($urandom_range(256, 400000)),
				cwm_pkg::DIM_W'($urandom_range(2, 4096)),
				cwm_pkg::DIM_W'($urandom_range(2, 4096)));
			random_pixels(45);
		end

		drain();
		$display("mapped %0d pixels across %0d register settings, %0d results checked",
			sent_pixels, settings_run, chk.checked);
		if (chk.errors == 0 && chk.pending_maps.size() == 0)
			$display("cylindrical_warp_mapper test passed");
		else
			$display("cylindrical_warp_mapper test failed");
		$finish;
	end

endmodule

// File: files.f
design/cwm_pkg.sv
design/cwm_row_search.sv
design/cwm_arc_lane.sv
design/cylindrical_warp_mapper.sv
verif/cylindrical_warp_mapper_test.sv
